>>> hdl/dtmr_pkg.sv
// dtmr_pkg: shared types, constants and helpers for the divider and reloading timer
// no dependencies; imported by divider_and_reloading_timer_top

package dtmr_pkg;

  // field widths
  localparam int CYCLES_W = 6;
  localparam int COUNT_W  = 8;
  localparam int CFG_W    = 8;
  localparam int IDX_W    = 2;
  // accumulator holds prescaler (up to 255) plus one step (up to 63)
  localparam int ACC_W    = 9;

  // divider period, a power of two so the split is a shift and a mask
  localparam int DIV_PERIOD = 64;
  localparam int DIV_SHIFT  = $clog2(DIV_PERIOD);

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_TIMER_ENABLE = 2'd0,
    REG_CLOCK_SELECT = 2'd1,
    REG_RELOAD_VALUE = 2'd2
  } cfg_reg_t;

  // timer period codes
  typedef enum logic [1:0] {
    SEL_256 = 2'd0,
    SEL_4   = 2'd1,
    SEL_16  = 2'd2,
    SEL_64  = 2'd3
  } clk_sel_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_EMIT
  } state_t;

  // timer period length for a select code
  function automatic logic [ACC_W-1:0] period_of(input logic [1:0] sel);
    logic [ACC_W-1:0] p;
    case (sel)
      SEL_256: p = 9'd256;
      SEL_4:   p = 9'd4;
      SEL_16:  p = 9'd16;
      SEL_64:  p = 9'd64;
      default: p = 9'd256;
    endcase
    return p;
  endfunction

endpackage

>>> hdl/divider_and_reloading_timer_top.sv
// divider_and_reloading_timer_top: free-running divider and reloading timer
// depends on dtmr_pkg
//
//  channel | ports                                            | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid, in_stall, in_elapsed_cycles, in_cpu_stopped | into block
//  out     | out_valid, out_stall, out_divider_value, out_timer_value,
//          | out_timer_overflow                               | out of block
//  cfg     | cfg_wr_en, cfg_index, cfg_wdata                  | into block
//
// with the timer enabled, a transaction steps once for each timer period elapsed
// (up to 79 periods with the shortest period) and then emits; with it disabled it goes straight to emit;
// the subtract-and-compare step on the timer accumulator retires one period a cycle.
// in_stall is high from acceptance until the result is loaded into the output register.
// a held out_stall keeps the finished result waiting in the emit state.
// rst_n is synchronous; reset clears counters, prescalers, state and config registers, not the output payload.

module divider_and_reloading_timer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dtmr_pkg::CYCLES_W-1:0] in_elapsed_cycles,
  input  logic                          in_cpu_stopped,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dtmr_pkg::COUNT_W-1:0]  out_divider_value,
  output logic [dtmr_pkg::COUNT_W-1:0]  out_timer_value,
  output logic                          out_timer_overflow,
  input  logic                          cfg_wr_en,
  input  logic [dtmr_pkg::IDX_W-1:0]    cfg_index,
  input  logic [dtmr_pkg::CFG_W-1:0]    cfg_wdata
);
  import dtmr_pkg::*;

  state_t             state_r, state_nxt;
  logic               tmr_en_r;
  logic [1:0]         clk_sel_r;
  logic [COUNT_W-1:0] reload_r;
  logic [COUNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [COUNT_W-1:0] div_pre_r, div_pre_nxt;
  logic [COUNT_W-1:0] tmr_cnt_r, tmr_cnt_nxt;
  logic [COUNT_W-1:0] tmr_pre_r, tmr_pre_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic               ovf_r, ovf_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_div_r, out_div_nxt;
  logic [COUNT_W-1:0] out_tmr_r, out_tmr_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  logic               in_take;
  logic               out_free;
  logic [ACC_W-1:0]   period;
  logic [ACC_W-1:0]   div_sum;
  logic [ACC_W-1:0]   div_steps;
  logic [COUNT_W-1:0] tmr_inc;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign period   = period_of(clk_sel_r);

  // divider split: quotient by shift, remainder by mask
  assign div_sum   = ACC_W'(div_pre_r) + ACC_W'(in_elapsed_cycles);
  assign div_steps = div_sum >> DIV_SHIFT;
  assign tmr_inc   = tmr_cnt_r + 8'd1;

  // configuration writes, unknown index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmr_en_r  <= 1'b0;
      clk_sel_r <= 2'd0;
      reload_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TIMER_ENABLE: tmr_en_r  <= cfg_wdata[0];
        REG_CLOCK_SELECT: clk_sel_r <= cfg_wdata[1:0];
        REG_RELOAD_VALUE: reload_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // state and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_cnt_r   <= '0;
      div_pre_r   <= '0;
      tmr_cnt_r   <= '0;
      tmr_pre_r   <= '0;
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      div_pre_r   <= div_pre_nxt;
      tmr_cnt_r   <= tmr_cnt_nxt;
      tmr_pre_r   <= tmr_pre_nxt;
      acc_r       <= acc_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    out_div_r <= out_div_nxt;
    out_tmr_r <= out_tmr_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  // sequencer: accept, step timer one period a cycle when enabled, emit
  always_comb begin
    state_nxt     = state_r;
    div_cnt_nxt   = div_cnt_r;
    div_pre_nxt   = div_pre_r;
    tmr_cnt_nxt   = tmr_cnt_r;
    tmr_pre_nxt   = tmr_pre_r;
    acc_nxt       = acc_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_div_nxt   = out_div_r;
    out_tmr_nxt   = out_tmr_r;
    out_ovf_nxt   = out_ovf_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          // divider updates at once unless the cpu is stopped
          if (!in_cpu_stopped) begin
            div_cnt_nxt = div_cnt_r + div_steps[COUNT_W-1:0];
            div_pre_nxt = div_sum[COUNT_W-1:0] & COUNT_W'(DIV_PERIOD - 1);
          end
          ovf_nxt = 1'b0;
          if (tmr_en_r) begin
            acc_nxt   = ACC_W'(tmr_pre_r) + ACC_W'(in_elapsed_cycles);
            state_nxt = S_STEP;
          end else begin
            // frozen timer: prescaler passes through unchanged
            acc_nxt   = ACC_W'(tmr_pre_r);
            state_nxt = S_EMIT;
          end
        end
      end
      S_STEP: begin
        if (acc_r >= period) begin
          acc_nxt = acc_r - period;
          if (tmr_inc == '0) begin
            tmr_cnt_nxt = reload_r;
            ovf_nxt     = 1'b1;
          end else begin
            tmr_cnt_nxt = tmr_inc;
          end
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          tmr_pre_nxt   = acc_r[COUNT_W-1:0];
          out_valid_nxt = 1'b1;
          out_div_nxt   = div_cnt_r;
          out_tmr_nxt   = tmr_cnt_r;
          out_ovf_nxt   = ovf_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_divider_value  = out_div_r;
  assign out_timer_value    = out_tmr_r;
  assign out_timer_overflow = out_ovf_r;

`ifndef SYNTHESIS
  // an accepted transaction always leaves idle
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> state_r != S_IDLE)
    else $error("accepted transaction did not start the sequencer");

  // accumulator never exceeds prescaler maximum plus one step
  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STEP |-> acc_r <= 9'd318)
    else $error("timer accumulator out of range");

  // leftover prescale fits in eight bits once stepping is done
  a_acc_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> acc_r[ACC_W-1] == 1'b0)
    else $error("timer prescale overflowed at emit");

  // a new result is loaded only when leaving the emit state
  a_load_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) || !out_valid_r |=>
      !out_valid_r || $past(state_r) == S_EMIT || $past(out_valid_r))
    else $error("result loaded outside emit state");
`endif

endmodule
